// File: design/bop_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bop_pkg: shared types and constants for the binomial option pricer
// Fixed-point constants, register map codes and the control and coefficient
// bundles that the controller broadcasts along the row of node cells.
// ----------------------------------------------------------------------------
package bop_pkg;

    // default and largest supported tree depth
    localparam int DEFAULT_MAX_LEVELS = 256;
    localparam int LEVELS_LIMIT       = 1024;

    // width of level counts and step thresholds, covers the whole depth range
    localparam int LVL_W = $clog2(LEVELS_LIMIT + 1);

    // apb address width for six 32-bit registers
    localparam int PADDR_W = 5;

    // q2.30 / q0.30 constants
    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [30:0] Q30_HALF = 31'h2000_0000;

    // register reset values
    localparam logic [31:0] RST_INITIAL_PRICE  = 32'h0000_0000;
    localparam logic [31:0] RST_STRIKE_PRICE   = 32'h0000_0000;
    localparam logic [31:0] RST_UP_FACTOR      = 32'h4000_0000;
    localparam logic [31:0] RST_DOWN_FACTOR    = 32'h4000_0000;
    localparam logic [30:0] RST_UP_PROBABILITY = 31'h2000_0000;
    localparam logic [30:0] RST_STEP_DISCOUNT  = 31'h4000_0000;

    // register indexes (word address)
    typedef enum logic [2:0] {
        REG_INITIAL_PRICE  = 3'd0,
        REG_STRIKE_PRICE   = 3'd1,
        REG_UP_FACTOR      = 3'd2,
        REG_DOWN_FACTOR    = 3'd3,
        REG_UP_PROBABILITY = 3'd4,
        REG_STEP_DISCOUNT  = 3'd5
    } t_reg_idx;

    // operation that every cell performs in a given cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_LEAF,
        OP_STRIKE,
        OP_MIX,
        OP_DISC
    } t_cell_op;

    // broadcast control: operation and the up/down split for leaf steps
    typedef struct packed {
        t_cell_op         op;
        logic [LVL_W-1:0] thr;
    } t_cell_ctrl;

    // broadcast pricing coefficients, probability and discount already clamped
    typedef struct packed {
        logic [31:0] s0;
        logic [31:0] strike;
        logic [31:0] up;
        logic [31:0] down;
        logic [30:0] prob;
        logic [30:0] disc;
    } t_coef;

endpackage : bop_pkg
`default_nettype wire

// File: design/bop_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bop_cell: one node column of the binomial tree
// Holds one node value and a sticky clip flag. A single multiply-add unit
// builds the leaf price step by step, then performs the two halves of each
// backward induction step using the value of the next cell up the row.
// ----------------------------------------------------------------------------
module bop_cell #(
    parameter int INDEX = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bop_pkg::t_cell_ctrl i_ctrl,
    input  wire bop_pkg::t_coef     i_coef,
    input  wire logic [31:0]        i_next_value,
    input  wire logic               i_next_clip,
    output logic [31:0]             o_value,
    output logic                    o_clip
);
    import bop_pkg::*;

    logic [31:0]        r_value;
    logic [31:0]        n_value;
    logic               r_clip;
    logic               n_clip;
    logic               use_up;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] product;
    logic signed [65:0] addend;
    logic signed [65:0] acc;
    logic [35:0]        scaled;

    // cells at or above the threshold take an up move in this leaf step
    assign use_up = (LVL_W'(INDEX) >= i_ctrl.thr);

    // operand selection for the shared multiply-add
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        addend = '0;
        case (i_ctrl.op)
            OP_LEAF: begin
                mul_a  = {1'b0, r_value};
                mul_b  = {1'b0, (use_up ? i_coef.up : i_coef.down)};
                addend = {35'd0, Q30_HALF};
            end
            OP_MIX: begin
                // q*lo + p*hi written as lo*2^30 + p*(hi - lo)
                mul_a  = $signed({1'b0, i_next_value}) - $signed({1'b0, r_value});
                mul_b  = {2'b00, i_coef.prob};
                addend = {4'd0, r_value, 30'd0} + {35'd0, Q30_HALF};
            end
            OP_DISC: begin
                mul_a  = {1'b0, r_value};
                mul_b  = {2'b00, i_coef.disc};
                addend = {35'd0, Q30_HALF};
            end
            default: begin
                mul_a  = '0;
                mul_b  = '0;
                addend = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;
    assign acc     = product + addend;
    assign scaled  = acc[65:30];

    // next value and clip flag
    always_comb begin
        n_value = r_value;
        n_clip  = r_clip;
        case (i_ctrl.op)
            OP_LOAD: begin
                n_value = i_coef.s0;
                n_clip  = 1'b0;
            end
            OP_LEAF: begin
                if (scaled[35:32] != 4'd0) begin
                    n_value = 32'hFFFF_FFFF;
                    n_clip  = 1'b1;
                end else begin
                    n_value = scaled[31:0];
                end
            end
            OP_STRIKE: begin
                n_value = (r_value > i_coef.strike) ? (r_value - i_coef.strike) : 32'd0;
            end
            OP_MIX: begin
                n_value = scaled[31:0];
            end
            OP_DISC: begin
                // clip flags collapse toward cell zero one column per level
                n_value = scaled[31:0];
                n_clip  = r_clip | i_next_clip;
            end
            default: begin
                n_value = r_value;
                n_clip  = r_clip;
            end
        endcase
    end

    // node value, no reset needed
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // clip flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= 1'b0;
        end else begin
            r_clip <= n_clip;
        end
    end

    assign o_value = r_value;
    assign o_clip  = r_clip;

endmodule : bop_cell
`default_nettype wire

// File: design/binomial_option_pricer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binomial_option_pricer: european call on a binomial tree
// Row of node cells with a sequencer, APB register file and output register.
// ----------------------------------------------------------------------------
// One word in gives the level count N (zero acts as one, values above
// MAX_LEVELS act as MAX_LEVELS) and one word out gives the root value in
// unsigned Q16.16 plus a flag for any clipped leaf price. From acceptance to
// the result register an item passes these steps: every cell applies one
// down or up factor to its leaf price per leaf step, the cells subtract the
// strike, then each tree level below the leaves takes a probability mix and
// then a discount because each cell owns a single multiply-add and a level
// needs the finished values of the level above; then the sequencer leaves
// the induction loop and loads the output register. A stalled receiver that
// still holds the result register delays that load. One item is in flight
// at a time; a finished result waits in the output register while the next
// word is accepted. Registers are to be written over APB while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module binomial_option_pricer #(
    parameter int MAX_LEVELS = bop_pkg::DEFAULT_MAX_LEVELS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // apb configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bop_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // input word
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [8:0]                  i_level_count,
    // output word
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [31:0]                      o_option_value,
    output logic                             o_saturated
);
    import bop_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAF,
        ST_MIX,
        ST_DISC,
        ST_DONE
    } t_state;

    // configuration registers
    logic [31:0] r_initial_price;
    logic [31:0] r_strike_price;
    logic [31:0] r_up_factor;
    logic [31:0] r_down_factor;
    logic [30:0] r_up_probability;
    logic [30:0] r_step_discount;

    // sequencer
    t_state            r_state;
    logic [LVL_W-1:0]  r_levels;
    logic [LVL_W-1:0]  r_count;
    logic [31:0]       r_option_value;
    logic              r_saturated;
    logic              r_out_valid;
    logic [LVL_W-1:0]  level_n;
    logic              in_accept;
    logic              cfg_write;
    t_cell_ctrl        ctrl;
    t_coef             coef;

    // cell row
    logic [31:0] cell_value [MAX_LEVELS];
    logic        cell_clip  [MAX_LEVELS];
    logic [31:0] next_value [MAX_LEVELS];
    logic        next_clip  [MAX_LEVELS];

    // apb register write
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_price  <= RST_INITIAL_PRICE;
            r_strike_price   <= RST_STRIKE_PRICE;
            r_up_factor      <= RST_UP_FACTOR;
            r_down_factor    <= RST_DOWN_FACTOR;
            r_up_probability <= RST_UP_PROBABILITY;
            r_step_discount  <= RST_STEP_DISCOUNT;
        end else if (cfg_write) begin
            case (paddr[4:2])
                REG_INITIAL_PRICE:  r_initial_price  <= pwdata;
                REG_STRIKE_PRICE:   r_strike_price   <= pwdata;
                REG_UP_FACTOR:      r_up_factor      <= pwdata;
                REG_DOWN_FACTOR:    r_down_factor    <= pwdata;
                REG_UP_PROBABILITY: r_up_probability <= pwdata[30:0];
                REG_STEP_DISCOUNT:  r_step_discount  <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    // apb register read
    always_comb begin
        case (paddr[4:2])
            REG_INITIAL_PRICE:  prdata = r_initial_price;
            REG_STRIKE_PRICE:   prdata = r_strike_price;
            REG_UP_FACTOR:      prdata = r_up_factor;
            REG_DOWN_FACTOR:    prdata = r_down_factor;
            REG_UP_PROBABILITY: prdata = {1'b0, r_up_probability};
            REG_STEP_DISCOUNT:  prdata = {1'b0, r_step_discount};
            default:            prdata = 32'd0;
        endcase
    end

    // coefficients, probability and discount clamped to one
    always_comb begin
        coef.s0     = r_initial_price;
        coef.strike = r_strike_price;
        coef.up     = r_up_factor;
        coef.down   = r_down_factor;
        coef.prob   = (r_up_probability > Q30_ONE) ? Q30_ONE : r_up_probability;
        coef.disc   = (r_step_discount > Q30_ONE) ? Q30_ONE : r_step_discount;
    end

    // level count with zero and overrange folded in
    always_comb begin
        if (i_level_count == 9'd0) begin
            level_n = LVL_W'(1);
        end else if (32'(i_level_count) > 32'(MAX_LEVELS)) begin
            level_n = LVL_W'(MAX_LEVELS);
        end else begin
            level_n = LVL_W'(i_level_count);
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_accept  = i_in_valid & o_in_ready;

    // cell operation for the current cycle
    always_comb begin
        ctrl.op  = OP_HOLD;
        ctrl.thr = r_count;
        case (r_state)
            ST_IDLE: ctrl.op = i_in_valid ? OP_LOAD : OP_HOLD;
            ST_LEAF: ctrl.op = (r_count != '0) ? OP_LEAF : OP_STRIKE;
            ST_MIX:  ctrl.op = (r_count != '0) ? OP_MIX : OP_HOLD;
            ST_DISC: ctrl.op = OP_DISC;
            default: ctrl.op = OP_HOLD;
        endcase
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_levels       <= '0;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
            r_option_value <= 32'd0;
            r_saturated    <= 1'b0;
        end else begin
            // the finishing state reloads the output register itself
            if (r_out_valid && i_out_ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_levels <= level_n;
                        r_count  <= level_n - LVL_W'(1);
                        r_state  <= ST_LEAF;
                    end
                end
                ST_LEAF: begin
                    if (r_count != '0) begin
                        r_count <= r_count - LVL_W'(1);
                    end else begin
                        r_count <= r_levels - LVL_W'(1);
                        r_state <= ST_MIX;
                    end
                end
                ST_MIX: begin
                    r_state <= (r_count != '0) ? ST_DISC : ST_DONE;
                end
                ST_DISC: begin
                    r_count <= r_count - LVL_W'(1);
                    r_state <= ST_MIX;
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_option_value <= cell_value[0];
                        r_saturated    <= cell_clip[0];
                        r_out_valid    <= 1'b1;
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_option_value = r_option_value;
    assign o_saturated    = r_saturated;

    // row of node cells, each reading the one above it
    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
        if (g == MAX_LEVELS - 1) begin : g_top
            assign next_value[g] = 32'd0;
            assign next_clip[g]  = 1'b0;
        end else begin : g_mid
            assign next_value[g] = cell_value[g+1];
            assign next_clip[g]  = cell_clip[g+1];
        end

        bop_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_coef       (coef),
            .i_next_value (next_value[g]),
            .i_next_clip  (next_clip[g]),
            .o_value      (cell_value[g]),
            .o_clip       (cell_clip[g])
        );
    end

`ifndef SYNTHESIS
    // an accepted word always leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("sequencer stayed idle after accepting a word");

    // the working level count is always within the tree depth
    a_levels_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_levels != '0 && 32'(r_levels) <= 32'(MAX_LEVELS)))
        else $error("level count out of range while busy");

    // step counter never passes the level count
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_levels)
        else $error("step counter above level count");

    // a new result only appears out of the finishing state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside the finishing state");
`endif

endmodule : binomial_option_pricer
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: binomial option pricer self-checking bench
// Drives level counts over valid/ready under several register settings
// written over APB, prices each word with a local fixed-point tree model and
// compares every returned root value and saturation flag in order.
// ----------------------------------------------------------------------------
module testbench;
    import bop_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int MAX_LEVELS     = bop_pkg::DEFAULT_MAX_LEVELS;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_WORDS    = 72;

    // expected root value and flag for one accepted level count
    typedef struct packed {
        logic [31:0] value;
        logic        saturated;
    } t_priced;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [8:0]  i_level_count = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_option_value;
    logic        o_saturated;

    // local copy of the register file
    logic [31:0] cfg_s0     = RST_INITIAL_PRICE;
    logic [31:0] cfg_strike = RST_STRIKE_PRICE;
    logic [31:0] cfg_up     = RST_UP_FACTOR;
    logic [31:0] cfg_down   = RST_DOWN_FACTOR;
    logic [30:0] cfg_prob   = RST_UP_PROBABILITY;
    logic [30:0] cfg_disc   = RST_STEP_DISCOUNT;

    logic [8:0] pending_levels[$];
    t_priced    expected_prices[$];

    int mismatch_count = 0;
    int words_sent     = 0;
    int words_priced   = 0;
    int saturated_seen = 0;
    int settings_count = 0;
    int deepest_tree   = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    int idle_cycles    = 0;
    int stall_mode     = 0;
    logic [15:0] stall_cnt = '0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    binomial_option_pricer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_level_count  (i_level_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_option_value (o_option_value),
        .o_saturated    (o_saturated)
    );

    // price times factor, round half up, clip flag in the top bit
    function automatic logic [32:0] scale_q30(input logic [31:0] price,
                                              input logic [31:0] factor);
        logic [63:0] prod;
        prod = (64'(price) * 64'(factor) + 64'(Q30_HALF)) >> 30;
        if (prod > 64'hFFFF_FFFF) begin
            return {1'b1, 32'hFFFF_FFFF};
        end
        return {1'b0, prod[31:0]};
    endfunction

    function automatic logic [63:0] clamp_one(input logic [30:0] frac);
        return (frac > Q30_ONE) ? 64'(Q30_ONE) : 64'(frac);
    endfunction

    // full tree: leaf prices, strike, then backward induction to the root
    function automatic t_priced crr_call_value(input logic [8:0] level_word);
        logic [31:0] nodes [MAX_LEVELS];
        logic [31:0] px;
        logic [32:0] sc;
        logic [63:0] p, q, disc, mix, v;
        logic        clip;
        int          levels;
        t_priced     res;
        levels = (level_word == 0) ? 1 :
                 ((level_word > MAX_LEVELS) ? MAX_LEVELS : int'(level_word));
        p    = clamp_one(cfg_prob);
        q    = 64'(Q30_ONE) - p;
        disc = clamp_one(cfg_disc);
        clip = 1'b0;
        for (int j = 0; j < levels; j++) begin
            px = cfg_s0;
            for (int k = 0; k < levels - 1 - j; k++) begin
                sc   = scale_q30(px, cfg_down);
                clip = clip | sc[32];
                px   = sc[31:0];
            end
            for (int k = 0; k < j; k++) begin
                sc   = scale_q30(px, cfg_up);
                clip = clip | sc[32];
                px   = sc[31:0];
            end
            nodes[j] = (px > cfg_strike) ? px - cfg_strike : 32'd0;
        end
        for (int lvl = levels - 1; lvl > 0; lvl--) begin
            for (int j = 0; j < lvl; j++) begin
                mix = (q * 64'(nodes[j]) + p * 64'(nodes[j + 1]) + 64'(Q30_HALF)) >> 30;
                v   = (mix * disc + 64'(Q30_HALF)) >> 30;
                nodes[j] = v[31:0];
            end
        end
        res.value     = nodes[0];
        res.saturated = clip;
        return res;
    endfunction

    // mostly shallow trees, a few deep ones and the out-of-range counts
    function automatic logic [8:0] random_level();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 78) return 9'($urandom_range(1, 24));
        if (pick < 90) return 9'($urandom_range(25, 128));
        if (pick < 96) return 9'($urandom_range(129, 256));
        return 9'($urandom_range(0, 511));
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch on %s: expected %h got %h", $time, field, want, got);
        end
    endtask

    // apb write: setup cycle, access cycle, then release
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_INITIAL_PRICE:  cfg_s0     = data;
            REG_STRIKE_PRICE:   cfg_strike = data;
            REG_UP_FACTOR:      cfg_up     = data;
            REG_DOWN_FACTOR:    cfg_down   = data;
            REG_UP_PROBABILITY: cfg_prob   = data[30:0];
            REG_STEP_DISCOUNT:  cfg_disc   = data[30:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] s0, input logic [31:0] strike,
                                 input logic [31:0] up, input logic [31:0] down,
                                 input logic [31:0] prob, input logic [31:0] disc);
        apb_write(REG_INITIAL_PRICE, s0);
        apb_write(REG_STRIKE_PRICE, strike);
        apb_write(REG_UP_FACTOR, up);
        apb_write(REG_DOWN_FACTOR, down);
        apb_write(REG_UP_PROBABILITY, prob);
        apb_write(REG_STEP_DISCOUNT, disc);
        settings_count++;
    endtask

    // market-like settings most of the time, raw 32-bit values now and then
    task automatic random_settings();
        logic [31:0] s0, strike, up, down, prob, disc;
        s0 = ($urandom_range(0, 7) == 0) ? $urandom :
             (($urandom_range(1, 400) << 16) | $urandom_range(0, 65535));
        case ($urandom_range(0, 7))
            0:       strike = $urandom;
            1:       strike = '0;
            default: strike = s0 - (s0 >> 3) + ($urandom % ((s0 >> 2) + 1));
        endcase
        up   = ($urandom_range(0, 7) == 0) ? $urandom :
               32'(Q30_ONE) + $urandom_range(0, 1 << 25);
        down = ($urandom_range(0, 7) == 0) ? $urandom :
               32'(Q30_ONE) - $urandom_range(0, 1 << 25);
        prob = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1 << 30);
        disc = ($urandom_range(0, 7) == 0) ? $urandom :
               32'(Q30_ONE) - $urandom_range(0, 1 << 20);
        load_settings(s0, strike, up, down, prob, disc);
    endtask

    // hold off until every queued word is priced and returned
    // sampled on the falling edge so the sender's updates have settled
    task automatic wait_drained();
        while (pending_levels.size() != 0 || i_in_valid || expected_prices.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // sender: bursts of words separated by random gaps
    always @(posedge i_clk) begin
        logic       next_valid;
        logic [8:0] next_level;
        t_priced    predicted;
        if (!i_rst_n) begin
            i_in_valid    <= 1'b0;
            i_level_count <= '0;
        end else begin
            next_valid = i_in_valid;
            next_level = i_level_count;
            if (i_in_valid && o_in_ready) begin
                predicted = crr_call_value(i_level_count);
                expected_prices = {expected_prices, predicted};
                words_sent++;
                if (predicted.saturated) saturated_seen++;
                if (int'(i_level_count) > deepest_tree) deepest_tree = int'(i_level_count);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_levels.size() != 0) begin
                    next_valid = 1'b1;
                    next_level = pending_levels.pop_front();
                    if (burst_left > 1) begin
                        burst_left <= burst_left - 1;
                    end else if ($urandom_range(0, 4) == 0) begin
                        burst_left <= $urandom_range(20, 60);
                        gap_left   <= $urandom_range(30, 80);
                    end else begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left   <= $urandom_range(0, 12);
                    end
                end
            end
            i_in_valid    <= next_valid;
            i_level_count <= next_level;
        end
    end

    // receiver: check each word, stall on a shifting pattern
    always @(posedge i_clk) begin
        t_priced want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                words_priced++;
                if (expected_prices.size() == 0) begin
                    note_mismatch("unexpected word", '0, o_option_value);
                end else begin
                    want = expected_prices.pop_front();
                    if (o_option_value !== want.value)
                        note_mismatch("option_value", want.value, o_option_value);
                    if (o_saturated !== want.saturated)
                        note_mismatch("saturated", 32'(want.saturated), 32'(o_saturated));
                end
            end
            stall_cnt <= stall_cnt + 1'b1;
            if (stall_cnt[8:0] == 9'd0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                2:       i_out_ready <= (stall_cnt[5:4] != 2'b00);
                default: i_out_ready <= (stall_cnt[6:0] >= 7'd40);
            endcase
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $time, idle_cycles);
            $display("FAIL binomial_option_pricer");
            $finish;
        end
    end

    // stimulus: directed trees per setting, then random settings and depths
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, zero spot so every root is zero
        pending_levels = '{9'd0, 9'd1, 9'd2};
        wait_drained();

        // at-the-money market setting, every depth edge
        load_settings(32'd100 << 16, 32'd100 << 16, 32'd1084479242, 32'd1063004406,
                      32'd536870912, 32'd1072668082);
        pending_levels = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd7, 9'd16, 9'd64, 9'd255,
                           9'd256, 9'd257, 9'd511, 9'd300};
        wait_drained();

        // spot and factors at full scale, zero strike: price clipping, probability above one
        load_settings('1, '0, '1, '1, '1, 32'(Q30_ONE));
        pending_levels = '{9'd1, 9'd2, 9'd3, 9'd9};
        wait_drained();

        // zero factors, probability and discount, strike equal to spot
        load_settings('1, '1, '0, '0, '0, '0);
        pending_levels = '{9'd1, 9'd2, 9'd6};
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_settings();
            repeat (PHASE_WORDS) pending_levels = {pending_levels, random_level()};
            wait_drained();
        end

        repeat (3 * MAX_LEVELS + 32) @(posedge i_clk);

        $display("priced %0d of %0d words under %0d register settings, depth up to %0d",
                 words_priced, words_sent, settings_count + 1, deepest_tree);
        $display("%0d words predicted saturated, %0d mismatches", saturated_seen,
                 mismatch_count);
        if (mismatch_count == 0 && expected_prices.size() == 0) begin
            $display("PASS binomial_option_pricer");
        end else begin
            $display("FAIL binomial_option_pricer");
        end
        $finish;
    end

endmodule

// File: files.f
design/bop_pkg.sv
design/bop_cell.sv
design/binomial_option_pricer.sv
tb/sv/testbench.sv
